FILE: src/assert_macros.svh
// Assertion macros used by the top level of the call state table.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// antecedent holds -> consequent in the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: src/tlcst_pkg.sv
// Shared types and constants of the call state table.
// Used by tlcst_ctrl, tlcst_dpath and the top level; depends on nothing.
`default_nettype none

package tlcst_pkg;

  localparam int unsigned NUM_LINES_DEF = 16;
  localparam int unsigned ST_W = 3;

  typedef enum logic [1:0] {
    CMD_PICKUP = 2'd0,
    CMD_HANGUP = 2'd1,
    CMD_DIAL   = 2'd2,
    CMD_CHAT   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    LS_ON_HOOK   = 3'd0,
    LS_RINGING   = 3'd1,
    LS_DIAL_TONE = 3'd2,
    LS_RING_BACK = 3'd3,
    LS_BUSY      = 3'd4,
    LS_CONNECTED = 3'd5,
    LS_ERROR     = 3'd6
  } line_state_t;

  typedef struct packed {
    logic [3:0]  client;
    line_state_t line_state;
    logic [3:0]  party;
    logic        refused;
    logic        last;
  } rslt_t;

  typedef struct packed {
    logic load;
    logic fetch_dl;
    logic plan;
    logic step;
    logic sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic line_ok;
    logic step_ok;
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: src/tlcst_ctrl.sv
// Sequencer of the call state table: accept, fetch, plan, two update steps; a bad line ends after fetch.
// Depends on tlcst_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none

module tlcst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output tlcst_pkg::ctl_cmd_t cmd,
  input  tlcst_pkg::ctl_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_PLAN  = 5'b00100,
    S_STEP0 = 5'b01000,
    S_STEP1 = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch_dl = 1'b1;
        state_nxt    = sts.line_ok ? S_PLAN : S_IDLE;
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = S_STEP0;
      end
      S_STEP0: begin
        cmd.sel = 1'b0;
        if (sts.step_ok) begin
          cmd.step  = 1'b1;
          state_nxt = S_STEP1;
        end
      end
      S_STEP1: begin
        cmd.sel = 1'b1;
        if (sts.step_ok) begin
          cmd.step  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/tlcst_dpath.sv
// Datapath of the call state table: line table memory, event rules, output word.
// Depends on tlcst_pkg; sequenced by tlcst_ctrl.
`default_nettype none

module tlcst_dpath #(
  parameter int unsigned NUM_LINES = tlcst_pkg::NUM_LINES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlcst_pkg::ctl_cmd_t cmd,
  output tlcst_pkg::ctl_sts_t sts,
  input  logic [1:0]          in_cmd,
  input  logic [3:0]          in_line,
  input  logic [3:0]          in_dialed,
  input  logic                in_dialed_found,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [3:0]          out_client,
  output logic [2:0]          out_line_state,
  output logic [3:0]          out_party,
  output logic                out_refused,
  output logic                out_last
);

  localparam int unsigned IW  = $clog2(NUM_LINES);
  localparam int unsigned EW  = tlcst_pkg::ST_W + 1 + IW;
  localparam int unsigned CMPW = 9;

  // table entry: {state, peer valid, peer}
  function automatic logic [EW-1:0] mk_ent(tlcst_pkg::line_state_t s, logic v,
                                           logic [IW-1:0] p);
    return {s, v, p};
  endfunction

  function automatic tlcst_pkg::rslt_t mk_rs(logic [3:0] c, tlcst_pkg::line_state_t s,
                                             logic [3:0] p, logic rf);
    tlcst_pkg::rslt_t r;
    r.client     = c;
    r.line_state = s;
    r.party      = p;
    r.refused    = rf;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic in_rng(logic [3:0] v);
    return CMPW'(v) < CMPW'(NUM_LINES);
  endfunction

  tlcst_pkg::cmd_t cmd_r;
  logic [3:0]      ln_r, dl_r;
  logic            found_r;

  logic [EW-1:0]        mem [NUM_LINES];
  logic [NUM_LINES-1:0] ent_vld_r;
  logic [EW-1:0]        rd_r, ln_ent_r;
  logic                 rd_vld_r;

  logic          ln_ok, dl_ok, rd_en, wr_en;
  logic [IW-1:0] in_idx, ln_idx, dl_idx, rd_addr, wr_addr;
  logic [EW-1:0] wr_data, rd_ent;

  tlcst_pkg::line_state_t ln_st, dl_st, pst;
  logic                   ln_pv, dl_pv;
  logic [IW-1:0]          ln_pr, pr;

  logic [1:0]        p_wv, p_rv;
  logic [IW-1:0]     p_wa [2];
  logic [EW-1:0]     p_wd [2];
  tlcst_pkg::rslt_t  p_rs [2];

  logic [1:0]        wv_r, rv_r;
  logic [IW-1:0]     wa_r [2];
  logic [EW-1:0]     wd_r [2];
  tlcst_pkg::rslt_t  rs_r [2];

  logic              out_valid_r, out_free, out_load;
  tlcst_pkg::rslt_t  out_word_r;

  assign ln_ok  = in_rng(ln_r);
  assign dl_ok  = in_rng(dl_r);
  assign in_idx = in_rng(in_line) ? IW'(in_line) : '0;
  assign ln_idx = ln_ok ? IW'(ln_r) : '0;
  assign dl_idx = dl_ok ? IW'(dl_r) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= tlcst_pkg::cmd_t'(in_cmd);
      ln_r    <= in_line;
      dl_r    <= in_dialed;
      found_r <= in_dialed_found;
    end
  end

  // line table: one write, one registered read
  assign rd_en   = cmd.load | cmd.fetch_dl;
  assign rd_addr = cmd.load ? in_idx : dl_idx;
  assign wr_en   = cmd.step & wv_r[cmd.sel];
  assign wr_addr = wa_r[cmd.sel];
  assign wr_data = wd_r[cmd.sel];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= ent_vld_r[rd_addr];
      end
    end
  end

  assign rd_ent = rd_vld_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.fetch_dl) begin
      ln_ent_r <= rd_ent;
    end
  end

  assign ln_st = tlcst_pkg::line_state_t'(ln_ent_r[EW-1 -: tlcst_pkg::ST_W]);
  assign ln_pv = ln_ent_r[IW];
  assign ln_pr = ln_ent_r[IW-1:0];
  assign pr    = ln_pv ? ln_pr : '0;
  assign dl_st = tlcst_pkg::line_state_t'(rd_ent[EW-1 -: tlcst_pkg::ST_W]);
  assign dl_pv = rd_ent[IW];
  assign pst   = (ln_st == tlcst_pkg::LS_RING_BACK) ? tlcst_pkg::LS_ON_HOOK
                                                    : tlcst_pkg::LS_DIAL_TONE;

  // event rules; rd_ent holds the dialed entry here
  always_comb begin
    p_wv    = '0;
    p_rv    = '0;
    p_wa[0] = ln_idx;
    p_wa[1] = ln_idx;
    p_wd[0] = '0;
    p_wd[1] = '0;
    p_rs[0] = '0;
    p_rs[1] = '0;
    case (cmd_r)
      tlcst_pkg::CMD_PICKUP: begin
        if (ln_st == tlcst_pkg::LS_ON_HOOK) begin
          p_wv[0] = 1'b1;
          p_wd[0] = mk_ent(tlcst_pkg::LS_DIAL_TONE, ln_pv, ln_pr);
          p_rv[0] = 1'b1;
          p_rs[0] = mk_rs(ln_r, tlcst_pkg::LS_DIAL_TONE, 4'd0, 1'b0);
        end else if (ln_st == tlcst_pkg::LS_RINGING && ln_pv) begin
          p_wv    = 2'b11;
          p_wd[0] = mk_ent(tlcst_pkg::LS_CONNECTED, ln_pv, ln_pr);
          p_wa[1] = pr;
          p_wd[1] = mk_ent(tlcst_pkg::LS_CONNECTED, 1'b1, ln_idx);
          p_rv    = 2'b11;
          p_rs[0] = mk_rs(ln_r, tlcst_pkg::LS_CONNECTED, 4'(pr), 1'b0);
          p_rs[1] = mk_rs(4'(pr), tlcst_pkg::LS_CONNECTED, ln_r, 1'b0);
        end
      end
      tlcst_pkg::CMD_HANGUP: begin
        if (ln_st == tlcst_pkg::LS_CONNECTED || ln_st == tlcst_pkg::LS_RINGING ||
            ln_st == tlcst_pkg::LS_RING_BACK) begin
          p_wv[0] = 1'b1;
          p_wd[0] = mk_ent(tlcst_pkg::LS_ON_HOOK, 1'b0, '0);
          p_rv[0] = 1'b1;
          p_rs[0] = mk_rs(ln_r, tlcst_pkg::LS_ON_HOOK, 4'd0, 1'b0);
          if (ln_pv) begin
            p_wv[1] = 1'b1;
            p_wa[1] = pr;
            p_wd[1] = mk_ent(pst, 1'b0, '0);
            p_rv[1] = 1'b1;
            p_rs[1] = mk_rs(4'(pr), pst, 4'd0, 1'b0);
          end
        end else if (ln_st == tlcst_pkg::LS_DIAL_TONE || ln_st == tlcst_pkg::LS_BUSY ||
                     ln_st == tlcst_pkg::LS_ERROR) begin
          p_wv[0] = 1'b1;
          p_wd[0] = mk_ent(tlcst_pkg::LS_ON_HOOK, ln_pv, ln_pr);
          p_rv[0] = 1'b1;
          p_rs[0] = mk_rs(ln_r, tlcst_pkg::LS_ON_HOOK, 4'd0, 1'b0);
        end
      end
      tlcst_pkg::CMD_DIAL: begin
        if (ln_st == tlcst_pkg::LS_DIAL_TONE) begin
          p_wv[0] = 1'b1;
          p_rv[0] = 1'b1;
          if (!found_r || !dl_ok) begin
            p_wd[0] = mk_ent(tlcst_pkg::LS_ERROR, ln_pv, ln_pr);
            p_rs[0] = mk_rs(ln_r, tlcst_pkg::LS_ERROR, 4'd0, 1'b0);
          end else if (dl_r == ln_r || dl_pv || dl_st != tlcst_pkg::LS_ON_HOOK) begin
            p_wd[0] = mk_ent(tlcst_pkg::LS_BUSY, ln_pv, ln_pr);
            p_rs[0] = mk_rs(ln_r, tlcst_pkg::LS_BUSY, 4'd0, 1'b0);
          end else begin
            p_wa[0] = dl_idx;
            p_wd[0] = mk_ent(tlcst_pkg::LS_RINGING, 1'b1, ln_idx);
            p_rs[0] = mk_rs(dl_r, tlcst_pkg::LS_RINGING, 4'd0, 1'b0);
            p_wv[1] = 1'b1;
            p_wd[1] = mk_ent(tlcst_pkg::LS_RING_BACK, 1'b1, dl_idx);
            p_rv[1] = 1'b1;
            p_rs[1] = mk_rs(ln_r, tlcst_pkg::LS_RING_BACK, 4'd0, 1'b0);
          end
        end
      end
      default: begin
        p_rv[0] = 1'b1;
        p_rs[0] = mk_rs(ln_r, ln_st,
                        (ln_st == tlcst_pkg::LS_CONNECTED) ? 4'(pr) : 4'd0,
                        !(ln_st == tlcst_pkg::LS_CONNECTED && ln_pv));
      end
    endcase
    p_rs[0].last = !p_rv[1];
    p_rs[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
      rv_r <= '0;
    end else if (cmd.plan) begin
      wv_r <= p_wv;
      rv_r <= p_rv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      wa_r <= p_wa;
      wd_r <= p_wd;
      rs_r <= p_rs;
    end
  end

  // output word register
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = cmd.step & rv_r[cmd.sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= rs_r[cmd.sel];
    end
  end

  assign sts.line_ok = ln_ok;
  assign sts.step_ok = !rv_r[cmd.sel] || out_free;

  assign out_valid      = out_valid_r;
  assign out_client     = out_word_r.client;
  assign out_line_state = out_word_r.line_state;
  assign out_party      = out_word_r.party;
  assign out_refused    = out_word_r.refused;
  assign out_last       = out_word_r.last;

endmodule

`default_nettype wire

FILE: src/telephone_line_call_state_table.sv
// Call state table top level: tlcst_ctrl sequences tlcst_dpath (uses tlcst_pkg).
// The next event is accepted only after the current one is done; output stalls hold its update steps.
// The output register takes each result word in its update step, after fetch and plan.
// The line table has one write and one registered read port: two reads, then up to two writes per event.
// Reset (rst_n, synchronous): all lines on hook, no peers, output empty, ready for input.
`default_nettype none
`include "assert_macros.svh"

module telephone_line_call_state_table #(
  parameter int unsigned NUM_LINES = tlcst_pkg::NUM_LINES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_line,
  input  logic [3:0] in_dialed,
  input  logic       in_dialed_found,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_client,
  output logic [2:0] out_line_state,
  output logic [3:0] out_party,
  output logic       out_refused,
  output logic       out_last
);

  tlcst_pkg::ctl_cmd_t ctl_cmd;
  tlcst_pkg::ctl_sts_t ctl_sts;

  tlcst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (ctl_cmd),
    .sts      (ctl_sts)
  );

  tlcst_dpath #(
    .NUM_LINES (NUM_LINES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctl_cmd),
    .sts             (ctl_sts),
    .in_cmd          (in_cmd),
    .in_line         (in_line),
    .in_dialed       (in_dialed),
    .in_dialed_found (in_dialed_found),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_client      (out_client),
    .out_line_state  (out_line_state),
    .out_party       (out_party),
    .out_refused     (out_refused),
    .out_last        (out_last)
  );

  `ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `ASSERT_NXT(a_fetch_after_load, clk, rst_n, ctl_cmd.load, ctl_cmd.fetch_dl)
  `ASSERT_NXT(a_plan_after_fetch, clk, rst_n, ctl_cmd.fetch_dl && ctl_sts.line_ok, ctl_cmd.plan)
  `ASSERT_IMP(a_step_needs_room, clk, rst_n, ctl_cmd.step, ctl_sts.step_ok)

endmodule

`default_nettype wire

FILE: tb/telephone_line_call_state_table_tb.sv
// Self-checking testbench for telephone_line_call_state_table.
// Depends on tlcst_pkg and the RTL. Predicts the call state table in the
// bench and checks every notification word in order.
`timescale 1ns / 1ps

module telephone_line_call_state_table_tb;

  localparam int unsigned LINES          = tlcst_pkg::NUM_LINES_DEF;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PRINT_CAP      = 100;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd = tlcst_pkg::CMD_PICKUP;
  logic [3:0] in_line = '0;
  logic [3:0] in_dialed = '0;
  logic       in_dialed_found = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_client;
  logic [2:0] out_line_state;
  logic [3:0] out_party;
  logic       out_refused;
  logic       out_last;

  // predicted line table
  tlcst_pkg::line_state_t line_tab [LINES];
  logic [3:0]             link_to  [LINES];
  bit                     link_ok  [LINES];
  tlcst_pkg::rslt_t       pending_notes [$];

  int unsigned n_errors  = 0;
  int unsigned n_events  = 0;
  int unsigned n_checked = 0;
  int unsigned quiet     = 0;
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  telephone_line_call_state_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_line         (in_line),
    .in_dialed       (in_dialed),
    .in_dialed_found (in_dialed_found),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_client      (out_client),
    .out_line_state  (out_line_state),
    .out_party       (out_party),
    .out_refused     (out_refused),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_note(logic [3:0] cl, tlcst_pkg::line_state_t st,
                                    logic [3:0] pt, logic rf);
    tlcst_pkg::rslt_t n;
    n.client     = cl;
    n.line_state = st;
    n.party      = pt;
    n.refused    = rf;
    n.last       = 1'b0;
    pending_notes.push_back(n);
  endfunction

  function automatic void predict_event(tlcst_pkg::cmd_t c, logic [3:0] ln,
                                        logic [3:0] dl, logic fd);
    tlcst_pkg::line_state_t st;
    tlcst_pkg::line_state_t pst;
    bit                     pv;
    logic [3:0]             pr;
    int unsigned            n0;
    tlcst_pkg::rslt_t       tail;
    n0 = pending_notes.size();
    st = line_tab[ln];
    pv = link_ok[ln];
    pr = pv ? link_to[ln] : 4'd0;
    case (c)
      tlcst_pkg::CMD_PICKUP: begin
        if (st == tlcst_pkg::LS_ON_HOOK) begin
          line_tab[ln] = tlcst_pkg::LS_DIAL_TONE;
          push_note(ln, tlcst_pkg::LS_DIAL_TONE, 4'd0, 1'b0);
        end else if (st == tlcst_pkg::LS_RINGING && pv) begin
          line_tab[ln] = tlcst_pkg::LS_CONNECTED;
          line_tab[pr] = tlcst_pkg::LS_CONNECTED;
          push_note(ln, tlcst_pkg::LS_CONNECTED, pr, 1'b0);
          push_note(pr, tlcst_pkg::LS_CONNECTED, ln, 1'b0);
        end
      end
      tlcst_pkg::CMD_HANGUP: begin
        if (st == tlcst_pkg::LS_CONNECTED || st == tlcst_pkg::LS_RINGING ||
            st == tlcst_pkg::LS_RING_BACK) begin
          pst = (st == tlcst_pkg::LS_RING_BACK) ? tlcst_pkg::LS_ON_HOOK
                                                : tlcst_pkg::LS_DIAL_TONE;
          line_tab[ln] = tlcst_pkg::LS_ON_HOOK;
          link_ok[ln]  = 1'b0;
          link_to[ln]  = 4'd0;
          push_note(ln, tlcst_pkg::LS_ON_HOOK, 4'd0, 1'b0);
          if (pv) begin
            line_tab[pr] = pst;
            link_ok[pr]  = 1'b0;
            link_to[pr]  = 4'd0;
            push_note(pr, pst, 4'd0, 1'b0);
          end
        end else if (st == tlcst_pkg::LS_DIAL_TONE || st == tlcst_pkg::LS_BUSY ||
                     st == tlcst_pkg::LS_ERROR) begin
          line_tab[ln] = tlcst_pkg::LS_ON_HOOK;
          push_note(ln, tlcst_pkg::LS_ON_HOOK, 4'd0, 1'b0);
        end
      end
      tlcst_pkg::CMD_DIAL: begin
        if (st == tlcst_pkg::LS_DIAL_TONE) begin
          if (!fd || dl >= LINES) begin
            line_tab[ln] = tlcst_pkg::LS_ERROR;
            push_note(ln, tlcst_pkg::LS_ERROR, 4'd0, 1'b0);
          end else if (dl == ln || link_ok[dl] ||
                       line_tab[dl] != tlcst_pkg::LS_ON_HOOK) begin
            line_tab[ln] = tlcst_pkg::LS_BUSY;
            push_note(ln, tlcst_pkg::LS_BUSY, 4'd0, 1'b0);
          end else begin
            link_to[ln]  = dl;
            link_ok[ln]  = 1'b1;
            link_to[dl]  = ln;
            link_ok[dl]  = 1'b1;
            line_tab[dl] = tlcst_pkg::LS_RINGING;
            line_tab[ln] = tlcst_pkg::LS_RING_BACK;
            push_note(dl, tlcst_pkg::LS_RINGING, 4'd0, 1'b0);
            push_note(ln, tlcst_pkg::LS_RING_BACK, 4'd0, 1'b0);
          end
        end
      end
      default: begin
        push_note(ln, st, (st == tlcst_pkg::LS_CONNECTED) ? pr : 4'd0,
                  !(st == tlcst_pkg::LS_CONNECTED && pv));
      end
    endcase
    if (pending_notes.size() > n0) begin
      tail = pending_notes.pop_back();
      tail.last = 1'b1;
      pending_notes.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(string what, tlcst_pkg::rslt_t got,
                                 tlcst_pkg::rslt_t want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("MISMATCH %s at %0t: got client=%0d state=%0d party=%0d ",
               what, $time, got.client, got.line_state, got.party,
               "refused=%0d last=%0d, want client=%0d state=%0d party=%0d ",
               got.refused, got.last, want.client, want.line_state, want.party,
               "refused=%0d last=%0d", want.refused, want.last);
  endtask

  // sends one event word; called at a rising edge, returns at the accepting edge
  task automatic send_event(tlcst_pkg::cmd_t c, logic [3:0] ln, logic [3:0] dl,
                            logic fd);
    bit taken;
    while (in_idle_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= c;
    in_line         <= ln;
    in_dialed       <= dl;
    in_dialed_found <= fd;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_event(c, ln, dl, fd);
    n_events++;
  endtask

  task automatic wait_for_notes(int unsigned settle);
    in_valid <= 1'b0;
    while (pending_notes.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // receiver stall, with a counted hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= out_idle_on && ($urandom_range(99) < 29);
    end
  end

  // notification checker; sampled mid-cycle, accepted at the next edge
  always @(negedge clk) begin
    tlcst_pkg::rslt_t got;
    tlcst_pkg::rslt_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got.client     = out_client;
      got.line_state = tlcst_pkg::line_state_t'(out_line_state);
      got.party      = out_party;
      got.refused    = out_refused;
      got.last       = out_last;
      if (pending_notes.size() == 0) begin
        want = '0;
        report_mismatch("unexpected word", got, want);
      end else begin
        want = pending_notes.pop_front();
        n_checked++;
        if (got !== want)
          report_mismatch("notification", got, want);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words pending",
               quiet, pending_notes.size());
      $display("telephone_line_call_state_table_tb: done, errors");
      $finish;
    end
  end

  task automatic test_directed;
    send_event(tlcst_pkg::CMD_CHAT,   4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_PICKUP, 4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_CHAT,   4'd0,  4'd15, 1'b1);
    send_event(tlcst_pkg::CMD_DIAL,   4'd0,  4'd15, 1'b0);
    send_event(tlcst_pkg::CMD_DIAL,   4'd0,  4'd15, 1'b1);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_PICKUP, 4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_DIAL,   4'd0,  4'd0,  1'b1);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_PICKUP, 4'd15, 4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_DIAL,   4'd15, 4'd0,  1'b1);
    send_event(tlcst_pkg::CMD_PICKUP, 4'd3,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_DIAL,   4'd3,  4'd0,  1'b1);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd3,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_PICKUP, 4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_CHAT,   4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_CHAT,   4'd15, 4'd15, 1'b1);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd15, 4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd0,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_PICKUP, 4'd5,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_DIAL,   4'd5,  4'd6,  1'b1);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd6,  4'd0,  1'b0);
    send_event(tlcst_pkg::CMD_DIAL,   4'd5,  4'd6,  1'b1);
    send_event(tlcst_pkg::CMD_HANGUP, 4'd5,  4'd0,  1'b0);
    wait_for_notes(8);
  endtask

  // mostly call sequences with random parties, some raw noise words
  task automatic test_random_calls(int unsigned quota);
    int unsigned stop_at;
    logic [3:0]  a;
    logic [3:0]  b;
    stop_at = n_events + quota;
    while (n_events < stop_at) begin
      if ($urandom_range(99) < 70) begin
        a = 4'($urandom);
        b = 4'($urandom);
        send_event(tlcst_pkg::CMD_PICKUP, a, 4'($urandom), 1'($urandom));
        send_event(tlcst_pkg::CMD_DIAL, a, b, $urandom_range(15) != 0);
        if ($urandom_range(1))
          send_event(tlcst_pkg::CMD_PICKUP, b, 4'($urandom), 1'($urandom));
        if ($urandom_range(1))
          send_event(tlcst_pkg::CMD_CHAT, $urandom_range(1) ? a : b,
                     4'($urandom), 1'($urandom));
        if ($urandom_range(3) != 0)
          send_event(tlcst_pkg::CMD_HANGUP, $urandom_range(1) ? a : b,
                     4'($urandom), 1'($urandom));
      end else begin
        send_event(tlcst_pkg::cmd_t'($urandom_range(3)), 4'($urandom),
                   4'($urandom), 1'($urandom));
      end
    end
    wait_for_notes(8);
  endtask

  task automatic test_no_idle(int unsigned quota);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    test_random_calls(quota);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // receiver holds off while chat words keep coming, so the input backs up
  task automatic test_backpressure;
    in_idle_on = 1'b0;
    hold_seq++;
    for (int i = 0; i < 40; i++)
      send_event(tlcst_pkg::CMD_CHAT, i[3:0], 4'($urandom), 1'($urandom));
    in_idle_on = 1'b1;
    wait_for_notes(8);
  endtask

  initial begin
    for (int i = 0; i < LINES; i++) begin
      line_tab[i] = tlcst_pkg::LS_ON_HOOK;
      link_to[i]  = 4'd0;
      link_ok[i]  = 1'b0;
    end
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_calls(600);
    test_no_idle(300);
    test_backpressure();
    test_random_calls(250);
    wait_for_notes(20);
    $display("covered: directed call flows, random call sequences with idling, a no-idle run");
    $display("and a long receiver hold-off; %0d events sent, %0d words checked",
             n_events, n_checked);
    if (n_errors == 0)
      $display("telephone_line_call_state_table_tb: done, clean");
    else
      $display("telephone_line_call_state_table_tb: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/tlcst_pkg.sv
src/tlcst_ctrl.sv
src/tlcst_dpath.sv
src/telephone_line_call_state_table.sv
tb/telephone_line_call_state_table_tb.sv
